// ===== hw/rtl/fpa_pkg.sv =====
// shared opcodes, constants and pipeline payload types for the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned FracBitsMax     = 16;
  localparam int unsigned NumW            = 32 + FracBitsMax;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_LT      = 4'd4,
    OP_GT      = 4'd5,
    OP_LE      = 4'd6,
    OP_GE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_t;

  // payload carried through the divider stages
  typedef struct packed {
    op_t         func;
    logic [31:0] res;
    logic        cmp;
    logic        ov;
    logic        dz;
    logic        neg;
    logic        div_sat;
    logic [31:0] den;
    logic [31:0] rem;
    logic [31:0] num_lo;
    logic [31:0] quo;
  } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpa_div_step.sv =====
// one registered restoring-division step: one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire fpa_pkg::item_t in_item,
  output logic               valid_r,
  output fpa_pkg::item_t     item_r
);
  import fpa_pkg::*;

  logic [32:0] shifted;
  logic        take;
  item_t       item_nxt;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted  = {in_item.rem, in_item.num_lo[31]};
    take     = shifted >= {1'b0, in_item.den};
    item_nxt = in_item;
    item_nxt.rem    = take ? 32'(shifted - {1'b0, in_item.den}) : shifted[31:0];
    item_nxt.num_lo = {in_item.num_lo[30:0], 1'b0};
    item_nxt.quo    = {in_item.quo[30:0], take};
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_alu.sv =====
// top level of the pipelined signed 32-bit fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
// Pipelined fixed-point ALU on signed 32-bit raw operands with FRAC_BITS fraction
// bits. One request is accepted every clock unless out_tready stalls the output;
// each result leaves in the order its request was accepted. The divider produces
// one quotient bit per stage over 32 stages; every opcode travels the same path so
// results never reorder. The whole pipeline advances whenever the output register
// is empty or being taken, so a stall on out_tready holds every stage and drops
// nothing. Multiply and divide round half away from zero; results beyond the
// signed 32-bit range saturate and set overflow; divide by zero returns zero with
// div_by_zero set.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // result_raw[31:0], compare_true[32],
                                       // overflow[33], div_by_zero[34]
);
  import fpa_pkg::*;

  localparam int unsigned Steps = 32;
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic [63:0] MinMag = 64'd2147483648;
  localparam logic [NumW-1:0] Half = NumW'((64'd1 << FRAC_BITS) >> 1);

  logic en;

  // stage a: input register
  logic               a_valid_r;
  op_t                a_func_r;
  logic signed [31:0] a_opa_r, a_opb_r;

  // stage b: simple ops resolved, product and divider setup registered
  logic               b_valid_r;
  item_t              b_item_r, b_item_nxt;
  logic signed [63:0] b_prod_r;

  // stage c: multiply rounding and saturation
  logic               c_valid_r;
  item_t              c_item_r, c_item_nxt;

  // divider stages
  logic  [Steps:0] d_valid;
  item_t           d_item [Steps+1];

  // output register
  logic  out_valid_r;
  item_t out_item_r, out_item_nxt;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_item_r.dz, out_item_r.ov, out_item_r.cmp, out_item_r.res};

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= d_valid[Steps];
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (en) begin
      a_func_r <= op_t'(in_tdata[3:0]);
      a_opa_r  <= in_tdata[35:4];
      a_opb_r  <= in_tdata[67:36];
    end
  end

  // stage b logic
  always_comb begin
    logic signed [32:0] sum, diff, incv, decv;
    logic [31:0]        mag_a, mag_b;
    logic [NumW-1:0]    num;
    logic               lt, eq;
    sum   = 33'(a_opa_r) + 33'(a_opb_r);
    diff  = 33'(a_opa_r) - 33'(a_opb_r);
    incv  = 33'(a_opa_r) + 33'sd1;
    decv  = 33'(a_opa_r) - 33'sd1;
    mag_a = a_opa_r[31] ? 32'(-a_opa_r) : a_opa_r;
    mag_b = a_opb_r[31] ? 32'(-a_opb_r) : a_opb_r;
    num   = NumW'(mag_a) << FRAC_BITS;
    lt    = a_opa_r < a_opb_r;
    eq    = a_opa_r == a_opb_r;
    b_item_nxt         = '0;
    b_item_nxt.func    = a_func_r;
    b_item_nxt.den     = mag_b;
    b_item_nxt.rem     = 32'(num >> 32);
    b_item_nxt.num_lo  = num[31:0];
    b_item_nxt.neg     = a_opa_r[31] != a_opb_r[31];
    b_item_nxt.div_sat = 32'(num >> 32) >= mag_b;
    unique case (a_func_r)
      OP_ADD: begin
        b_item_nxt.ov  = sum[32] != sum[31];
        b_item_nxt.res = !b_item_nxt.ov ? sum[31:0] : (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff);
      end
      OP_SUB: begin
        b_item_nxt.ov  = diff[32] != diff[31];
        b_item_nxt.res = !b_item_nxt.ov ? diff[31:0] :
                         (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff);
      end
      OP_MUL: b_item_nxt.res = '0;
      OP_DIV: b_item_nxt.dz = mag_b == '0;
      OP_LT:  b_item_nxt.cmp = lt;
      OP_GT:  b_item_nxt.cmp = !lt && !eq;
      OP_LE:  b_item_nxt.cmp = lt || eq;
      OP_GE:  b_item_nxt.cmp = !lt;
      OP_EQ:  b_item_nxt.cmp = eq;
      OP_NE:  b_item_nxt.cmp = !eq;
      OP_MIN: b_item_nxt.res = lt ? a_opa_r : a_opb_r;
      OP_MAX: b_item_nxt.res = lt ? a_opb_r : a_opa_r;
      OP_INC: begin
        b_item_nxt.ov  = incv[32] != incv[31];
        b_item_nxt.res = b_item_nxt.ov ? 32'h7fff_ffff : incv[31:0];
      end
      OP_DEC: begin
        b_item_nxt.ov  = decv[32] != decv[31];
        b_item_nxt.res = b_item_nxt.ov ? 32'h8000_0000 : decv[31:0];
      end
      OP_TOINT: b_item_nxt.res = 32'(a_opa_r >>> FRAC_BITS);
      OP_FROMINT: begin
        if (a_opa_r[31]) begin
          b_item_nxt.ov  = num > NumW'(MinMag);
          b_item_nxt.res = b_item_nxt.ov ? 32'h8000_0000 : 32'(-num);
        end else begin
          b_item_nxt.ov  = num > NumW'(Max32);
          b_item_nxt.res = b_item_nxt.ov ? 32'h7fff_ffff : num[31:0];
        end
      end
      default: b_item_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item_r <= b_item_nxt;
      b_prod_r <= 64'(a_opa_r) * 64'(a_opb_r);
    end
  end

  // stage c: round and saturate the product
  always_comb begin
    logic [63:0] pmag, q;
    pmag = b_prod_r[63] ? 64'(-b_prod_r) : 64'(b_prod_r);
    q    = (pmag + 64'(Half)) >> FRAC_BITS;
    c_item_nxt = b_item_r;
    if (b_item_r.func == OP_MUL) begin
      if (b_prod_r[63]) begin
        c_item_nxt.ov  = q > MinMag;
        c_item_nxt.res = c_item_nxt.ov ? 32'h8000_0000 : 32'(-q);
      end else begin
        c_item_nxt.ov  = q > 64'(Max32);
        c_item_nxt.res = c_item_nxt.ov ? 32'h7fff_ffff : q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_item_r <= c_item_nxt;
    end
  end

  // divider chain
  assign d_valid[0] = c_valid_r;
  assign d_item[0]  = c_item_r;

  for (genvar i = 0; i < Steps; i++) begin : g_div
    fpa_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (d_valid[i]),
      .in_item  (d_item[i]),
      .valid_r  (d_valid[i+1]),
      .item_r   (d_item[i+1])
    );
  end

  // final: divide rounding, sign and saturation
  always_comb begin
    item_t       it;
    logic        up;
    logic [32:0] qr;
    it = d_item[Steps];
    up = {it.rem, 1'b0} >= {1'b0, it.den};
    qr = {1'b0, it.quo} + 33'(up);
    out_item_nxt = it;
    if (it.func == OP_DIV && !it.dz) begin
      if (it.neg) begin
        out_item_nxt.ov  = it.div_sat || qr > 33'(MinMag);
        out_item_nxt.res = out_item_nxt.ov ? 32'h8000_0000 : 32'(-qr);
      end else begin
        out_item_nxt.ov  = it.div_sat || qr > 33'(Max32);
        out_item_nxt.res = out_item_nxt.ov ? 32'h7fff_ffff : qr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire
